### design/assert_macros.svh
// assertion helpers used by esc_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// consequence checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// constants and day-count helpers for the epoch to calendar converter
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  localparam int unsigned BASE_YEAR = 1970;

  // reciprocal constants: x / 60 = (x * RECIP_60) >> 37, x / 24 = (x * RECIP_24) >> 36
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;
  localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;

  // approx 4 / 1461 scaled by 2^24, used only as a year estimate
  localparam logic [15:0] YEAR_RECIP = 16'd45934;

  // year index of 2100, the only non-leap century in range
  localparam logic [7:0]  LAST_LEAP_GAP_IDX = 8'd130;
  localparam logic [11:0] NONLEAP_CENTURY   = 12'd2100;

  // first day of year (base + idx), counted from the epoch
  function automatic logic [16:0] year_start(input logic [7:0] idx);
    logic [16:0] base;
    logic [8:0]  leaps;
    base  = 17'(idx) * 17'd365;
    leaps = (9'(idx) + 9'd1) >> 2;
    if (idx > LAST_LEAP_GAP_IDX) begin
      leaps = leaps - 9'd1;
    end
    return base + 17'(leaps);
  endfunction

  // first day of month m (0 is january) within the year
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd334;
    endcase
    if (leap && (m >= 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### design/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to gregorian date and time
// one register stage per step of the conversion
// throughput one transaction per cycle while the output is not stalled
// synchronous reset empties the pipeline; no other state
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        epoch_valid,
  output logic             epoch_stall,
  input  wire logic [31:0] epoch_seconds,
  output logic             date_valid,
  input  wire logic        date_stall,
  output logic [11:0]      year_out,
  output logic [3:0]       month_out,
  output logic [4:0]       day_out,
  output logic [4:0]       hour_out,
  output logic [5:0]       minute_out,
  output logic [5:0]       second_out
);

  localparam int STAGES = 11;

  logic [STAGES-1:0] vld;
  logic              adv;

  // stage registers
  logic [31:0] t1;
  logic [63:0] p1;
  logic [26:0] m2, m3;
  logic [58:0] p2;
  logic [20:0] h4, h5;
  logic [52:0] p3;
  logic [15:0] d6, d7;
  logic [31:0] p4;
  logic [5:0]  sec2, sec3, sec4, sec5, sec6, sec7, sec8, sec9, sec10;
  logic [5:0]  min4, min5, min6, min7, min8, min9, min10;
  logic [4:0]  hr6, hr7, hr8, hr9, hr10;
  logic [7:0]  est8;
  logic [2:0]  neg8;
  logic [8:0]  rem8_0, rem8_1, rem8_2;
  logic [11:0] yr9, yr10;
  logic [8:0]  rem9, rem10;
  logic        leap9, leap10;
  logic [3:0]  mon10;

  // combinational helpers
  logic [31:0] sec_w;
  logic [26:0] min_w;
  logic [20:0] hr_w;
  logic [7:0]  est_raw, est_c;
  logic [16:0] diff0, diff1, diff2;
  logic [7:0]  idx_c;
  logic [8:0]  rem_c;
  logic [11:0] yr_c;
  logic [3:0]  mon_c;
  logic [8:0]  day_w;

  assign date_valid  = vld[STAGES-1];
  assign adv         = !(vld[STAGES-1] && date_stall);
  assign epoch_stall = !adv;

  always_comb begin
    sec_w   = t1 - (32'(p1[63:37]) * 32'd60);
    min_w   = m3 - (27'(p2[57:37]) * 27'd60);
    hr_w    = h5 - (21'(p3[51:36]) * 21'd24);
    est_raw = p4[31:24];
    est_c   = (est_raw == 8'd0) ? 8'd0 : est_raw - 8'd1;
    diff0   = 17'(d7) - esc_pkg::year_start(est_c);
    diff1   = 17'(d7) - esc_pkg::year_start(est_c + 8'd1);
    diff2   = 17'(d7) - esc_pkg::year_start(est_c + 8'd2);
  end

  always_comb begin
    if (!neg8[2]) begin
      idx_c = est8 + 8'd2;
      rem_c = rem8_2;
    end else if (!neg8[1]) begin
      idx_c = est8 + 8'd1;
      rem_c = rem8_1;
    end else begin
      idx_c = est8;
      rem_c = rem8_0;
    end
    yr_c = 12'(esc_pkg::BASE_YEAR) + 12'(idx_c);
  end

  always_comb begin
    mon_c = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (rem9 >= esc_pkg::month_start(4'(m), leap9)) begin
        mon_c = mon_c + 4'd1;
      end
    end
    day_w = rem10 - esc_pkg::month_start(mon10, leap10) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], epoch_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // seconds
      t1     <= epoch_seconds;
      p1     <= 64'(epoch_seconds) * 64'(esc_pkg::RECIP_60);
      m2     <= p1[63:37];
      sec2   <= sec_w[5:0];
      // minutes
      m3     <= m2;
      sec3   <= sec2;
      p2     <= 59'(m2) * 59'(esc_pkg::RECIP_60);
      h4     <= p2[57:37];
      min4   <= min_w[5:0];
      sec4   <= sec3;
      // hours
      h5     <= h4;
      min5   <= min4;
      sec5   <= sec4;
      p3     <= 53'(h4) * 53'(esc_pkg::RECIP_24);
      d6     <= p3[51:36];
      hr6    <= hr_w[4:0];
      min6   <= min5;
      sec6   <= sec5;
      // year estimate
      p4     <= 32'(d6) * 32'(esc_pkg::YEAR_RECIP);
      d7     <= d6;
      hr7    <= hr6;
      min7   <= min6;
      sec7   <= sec6;
      // candidate years
      est8   <= est_c;
      neg8   <= {diff2[16], diff1[16], diff0[16]};
      rem8_0 <= diff0[8:0];
      rem8_1 <= diff1[8:0];
      rem8_2 <= diff2[8:0];
      hr8    <= hr7;
      min8   <= min7;
      sec8   <= sec7;
      // year select
      yr9    <= yr_c;
      rem9   <= rem_c;
      leap9  <= (yr_c[1:0] == 2'd0) && (yr_c != esc_pkg::NONLEAP_CENTURY);
      hr9    <= hr8;
      min9   <= min8;
      sec9   <= sec8;
      // month select
      mon10  <= mon_c;
      rem10  <= rem9;
      leap10 <= leap9;
      yr10   <= yr9;
      hr10   <= hr9;
      min10  <= min9;
      sec10  <= sec9;
      // output
      year_out   <= yr10;
      month_out  <= mon10 + 4'd1;
      day_out    <= day_w[4:0];
      hour_out   <= hr10;
      minute_out <= min10;
      second_out <= sec10;
    end
  end

endmodule

`default_nettype wire

### design/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker
// port-level checks for the epoch to calendar converter
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module esc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        epoch_stall,
  input wire logic        date_valid,
  input wire logic        date_stall,
  input wire logic [11:0] year_out,
  input wire logic [3:0]  month_out,
  input wire logic [4:0]  day_out,
  input wire logic [4:0]  hour_out,
  input wire logic [5:0]  minute_out,
  input wire logic [5:0]  second_out
);

  // a stalled transaction holds its fields
  `ASSERT_NEXT(a_out_hold, clk, rst, date_valid && date_stall, date_valid && $stable(year_out) && $stable(month_out) && $stable(day_out) && $stable(hour_out) && $stable(minute_out) && $stable(second_out))

  // input back-pressure only comes from a stalled output
  `ASSERT_IMPL(a_stall_source, clk, rst, epoch_stall, date_valid && date_stall)

  `ASSERT_IMPL(a_date_range, clk, rst, date_valid, (month_out >= 4'd1) && (month_out <= 4'd12) && (day_out >= 5'd1) && (year_out >= 12'd1970) && (year_out <= 12'd2106))

  `ASSERT_IMPL(a_time_range, clk, rst, date_valid, (hour_out < 5'd24) && (minute_out < 6'd60) && (second_out < 6'd60))

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
  .clk         (clk),
  .rst         (rst),
  .epoch_stall (epoch_stall),
  .date_valid  (date_valid),
  .date_stall  (date_stall),
  .year_out    (year_out),
  .month_out   (month_out),
  .day_out     (day_out),
  .hour_out    (hour_out),
  .minute_out  (minute_out),
  .second_out  (second_out)
);

`default_nettype wire

### verif/epoch_seconds_to_calendar_checker.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_checker
// watches both channels of the converter, works out the calendar date of
// every accepted timestamp and compares each delivered date field by field,
// in order, against the oldest date still pending
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              epoch_valid,
  input  logic              epoch_stall,
  input  logic [31:0]       epoch_seconds,
  input  logic              date_valid,
  input  logic              date_stall,
  input  logic [11:0]       year_out,
  input  logic [3:0]        month_out,
  input  logic [4:0]        day_out,
  input  logic [4:0]        hour_out,
  input  logic [5:0]        minute_out,
  input  logic [5:0]        second_out,
  output int unsigned       mismatches,
  output int unsigned       dates_pending,
  output int unsigned       dates_checked
);

  typedef struct packed {
    logic [31:0] stamp;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  calendar_t   pending_dates[$];
  int unsigned mismatch_tally = 0;
  int unsigned checked_tally = 0;

  initial begin
    mismatches    = 0;
    dates_pending = 0;
    dates_checked = 0;
  end

  function automatic bit gregorian_leap(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_of_month(input int unsigned y, input int unsigned m);
    case (m)
      1:             return gregorian_leap(y) ? 29 : 28;
      3, 5, 8, 10:   return 30;
      default:       return 31;
    endcase
  endfunction

  // month index is 0 based inside, 1 based on the port
  function automatic calendar_t calendar_of_seconds(input logic [31:0] stamp);
    calendar_t   c;
    int unsigned t;
    int unsigned days;
    int unsigned yr;
    int unsigned mo;
    c.stamp  = stamp;
    c.second = 6'(stamp % 60);
    t        = stamp / 60;
    c.minute = 6'(t % 60);
    t        = t / 60;
    c.hour   = 5'(t % 24);
    days     = t / 24;
    yr       = esc_pkg::BASE_YEAR;
    while (days >= (gregorian_leap(yr) ? 366 : 365)) begin
      days = days - (gregorian_leap(yr) ? 366 : 365);
      yr++;
    end
    mo = 0;
    while (mo < 11 && days >= days_of_month(yr, mo)) begin
      days = days - days_of_month(yr, mo);
      mo++;
    end
    c.year  = 12'(yr);
    c.month = 4'(mo + 1);
    c.day   = 5'(days + 1);
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] date mismatch: %s", $realtime, msg);
    mismatch_tally++;
  endtask

  task automatic compare_field(input string field, input logic [31:0] stamp,
                               input int unsigned got, input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s for %0d seconds: got %0d, expected %0d",
                                field, stamp, got, want));
    end
  endtask

  always @(posedge clk) begin
    calendar_t want;
    if (!rst) begin
      if (epoch_valid && !epoch_stall) begin
        pending_dates.push_back(calendar_of_seconds(epoch_seconds));
      end
      if (date_valid && !date_stall) begin
        if (pending_dates.size() == 0) begin
          report_mismatch($sformatf("date %0d-%0d-%0d with no timestamp pending",
                                    year_out, month_out, day_out));
        end else begin
          want = pending_dates.pop_front();
          compare_field("year", want.stamp, year_out, want.year);
          compare_field("month", want.stamp, month_out, want.month);
          compare_field("day", want.stamp, day_out, want.day);
          compare_field("hour", want.stamp, hour_out, want.hour);
          compare_field("minute", want.stamp, minute_out, want.minute);
          compare_field("second", want.stamp, second_out, want.second);
          checked_tally++;
        end
      end
    end
    mismatches    <= mismatch_tally;
    dates_pending <= pending_dates.size();
    dates_checked <= checked_tally;
  end

endmodule

### verif/epoch_seconds_to_calendar_test.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_test
// drives timestamps into the converter with random gaps and output stalls,
// including one long output hold that backs up the pipeline; directed
// stamps cover the epoch, time-of-day rollovers, month and year ends, leap
// days under the 4, 100 and 400 year rules and the largest count
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_test;

  localparam int unsigned RANDOM_STAMPS = 530;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned DRAIN_CYCLES  = 40;

  logic        clk;
  logic        rst;
  logic        epoch_valid;
  logic        epoch_stall;
  logic [31:0] epoch_seconds;
  logic        date_valid;
  logic        date_stall;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;

  int unsigned mismatches;
  int unsigned dates_pending;
  int unsigned dates_checked;
  int unsigned stamps_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  epoch_seconds_to_calendar i_dut (
    .clk           (clk),
    .rst           (rst),
    .epoch_valid   (epoch_valid),
    .epoch_stall   (epoch_stall),
    .epoch_seconds (epoch_seconds),
    .date_valid    (date_valid),
    .date_stall    (date_stall),
    .year_out      (year_out),
    .month_out     (month_out),
    .day_out       (day_out),
    .hour_out      (hour_out),
    .minute_out    (minute_out),
    .second_out    (second_out)
  );

  epoch_seconds_to_calendar_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .epoch_valid   (epoch_valid),
    .epoch_stall   (epoch_stall),
    .epoch_seconds (epoch_seconds),
    .date_valid    (date_valid),
    .date_stall    (date_stall),
    .year_out      (year_out),
    .month_out     (month_out),
    .day_out       (day_out),
    .hour_out      (hour_out),
    .minute_out    (minute_out),
    .second_out    (second_out),
    .mismatches    (mismatches),
    .dates_pending (dates_pending),
    .dates_checked (dates_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("run stopped after %0d cycles with %0d dates pending",
                 cycle_count, dates_pending);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    case (m)
      2:             return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // seconds since the epoch for a date with month and day counted from 1
  function automatic logic [31:0] stamp_of(input int unsigned y, input int unsigned m,
                                           input int unsigned d, input int unsigned h,
                                           input int unsigned mi, input int unsigned s);
    longint unsigned days;
    days = 0;
    for (int unsigned yy = 1970; yy < y; yy++) begin
      days += month_length(yy, 2) == 29 ? 366 : 365;
    end
    for (int unsigned mm = 1; mm < m; mm++) begin
      days += month_length(y, mm);
    end
    days += d - 1;
    return 32'(((days * 24 + h) * 60 + mi) * 60 + s);
  endfunction

  function automatic logic [31:0] random_stamp();
    int unsigned r;
    int unsigned y;
    int unsigned m;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return $urandom();
    end else if (r < 80) begin
      y = $urandom_range(1970, 2105);
      m = $urandom_range(1, 12);
      if ($urandom_range(0, 1) == 1) begin
        if ($urandom_range(0, 1) == 1) begin
          return stamp_of(y, m, month_length(y, m), 23, 59, 59);
        end
        return stamp_of(y, m, month_length(y, m), $urandom_range(0, 23),
                        $urandom_range(0, 59), $urandom_range(0, 59));
      end
      if ($urandom_range(0, 1) == 1) begin
        return stamp_of(y, m, 1, 0, 0, 0);
      end
      return stamp_of(y, m, 1, $urandom_range(0, 23), $urandom_range(0, 59),
                      $urandom_range(0, 59));
    end else if (r < 90) begin
      return $urandom_range(0, 32'h00FF_FFFF);
    end
    return 32'hFFFF_FFFF - $urandom_range(0, 32'h00FF_FFFF);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = 30;
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_stamp(input logic [31:0] stamp);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      epoch_valid <= 1'b0;
    end
    @(negedge clk);
    epoch_valid   <= 1'b1;
    epoch_seconds <= stamp;
    do @(posedge clk); while (epoch_stall);
    stamps_sent++;
  endtask

  // output side: random stalls, stall-free stretches, and one long hold
  initial begin
    int unsigned r;
    int unsigned run_len;
    int unsigned stall_len;
    bit          held;
    held       = 1'b0;
    date_stall = 1'b0;
    wait (!rst);
    forever begin
      if (!held && stamps_sent >= 150) begin
        held = 1'b1;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          date_stall <= 1'b1;
        end
      end
      r = $urandom_range(0, 99);
      if (r < 20) begin
        run_len   = 40;
        stall_len = 0;
      end else begin
        run_len = $urandom_range(1, 12);
        if (r < 75) stall_len = $urandom_range(1, 3);
        else if (r < 95) stall_len = $urandom_range(4, 10);
        else stall_len = $urandom_range(20, 40);
      end
      repeat (run_len) begin
        @(negedge clk);
        date_stall <= 1'b0;
      end
      repeat (stall_len) begin
        @(negedge clk);
        date_stall <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] directed_stamps[$];
    rst           = 1'b1;
    epoch_valid   = 1'b0;
    epoch_seconds = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_stamps.push_back(32'd0);
    directed_stamps.push_back(32'd59);
    directed_stamps.push_back(32'd60);
    directed_stamps.push_back(32'd3599);
    directed_stamps.push_back(32'd3600);
    directed_stamps.push_back(32'd86399);
    directed_stamps.push_back(32'd86400);
    directed_stamps.push_back(stamp_of(1970, 1, 31, 23, 59, 59));
    directed_stamps.push_back(stamp_of(1970, 2, 1, 0, 0, 0));
    directed_stamps.push_back(stamp_of(1970, 12, 31, 23, 59, 59));
    directed_stamps.push_back(stamp_of(1971, 1, 1, 0, 0, 0));
    directed_stamps.push_back(stamp_of(1972, 2, 29, 12, 30, 30));
    directed_stamps.push_back(stamp_of(1972, 3, 1, 0, 0, 0));
    directed_stamps.push_back(stamp_of(2000, 2, 29, 23, 59, 59));
    directed_stamps.push_back(stamp_of(2000, 12, 31, 23, 59, 59));
    directed_stamps.push_back(stamp_of(2100, 2, 28, 23, 59, 59));
    directed_stamps.push_back(stamp_of(2100, 3, 1, 0, 0, 0));
    directed_stamps.push_back(stamp_of(2038, 1, 19, 3, 14, 7));
    directed_stamps.push_back(32'h8000_0000);
    directed_stamps.push_back(32'h5555_5555);
    directed_stamps.push_back(32'hAAAA_AAAA);
    directed_stamps.push_back(32'hFFFF_FFFE);
    directed_stamps.push_back(32'hFFFF_FFFF);

    foreach (directed_stamps[i]) begin
      send_stamp(directed_stamps[i]);
    end
    repeat (RANDOM_STAMPS) begin
      send_stamp(random_stamp());
    end
    @(negedge clk);
    epoch_valid <= 1'b0;

    while (dates_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d timestamps sent and %0d dates checked in %0d cycles,",
             stamps_sent, dates_checked, cycle_count);
    $display("spanning 1970 to 2106 with month ends, leap days and a long output hold");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
